### rtl/bsr_pkg.sv
// Shared types and codes for the bounded stack with remove.
// Holds the request and response transaction structs and the operation/status codes.
// No dependencies.
package bsr_pkg;

   // Fixed field widths of the transaction payloads
   localparam int REQ_TYPE_W  = 3;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   // Operation codes
   localparam logic [REQ_TYPE_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_POP    = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_CLEAR  = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [VALUE_W-1:0]    value_in;
   } bsr_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [VALUE_W-1:0]     value_out;
      logic [COUNT_OUT_W-1:0] count_out;
   } bsr_rsp_type;

endpackage

### rtl/bsr_store.sv
// Entry storage for the bounded stack: one write port, one registered read port.
// Stand-alone; no package needed.
module bsr_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bounded_stack_with_remove.sv
// Top level of the bounded stack with remove: sequencer, count and response register.
// Depends on bsr_pkg and bsr_store.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+-------------------------------
//   request | req_valid, req_stall, req_data | in        | req_type, value_in
//   result  | rsp_valid, rsp_stall, rsp_data | out       | status, value_out, count_out
//
// Push, pop, clear, unused codes and rejected requests answer from idle; peek from S_PEEK.
// Remove walks the entries through the single read port, one entry a cycle, and on a
// match moves each entry above it down one place before answering.
// Reset clears the count and control state; entry contents are undefined until pushed.
// req_stall is high while a request is in progress, or while a finished response
// is still held by rsp_stall and the register cannot take another.
module bounded_stack_with_remove #(
   parameter int CAPACITY   = 16,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  bsr_pkg::bsr_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bsr_pkg::bsr_rsp_type rsp_data
);

   import bsr_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_PEEK   = 4'b0010,
      S_SEARCH = 4'b0100,
      S_SHIFT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [ELEM_WIDTH-1:0] val_ff, val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bsr_rsp_type       rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              out_free;
   logic              rsp_load;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_value;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [ELEM_WIDTH-1:0] rd_data;

   logic [ELEM_WIDTH+VALUE_W-1:0]  req_value_ext;
   logic [ELEM_WIDTH-1:0]          req_value;
   logic [VALUE_W+ELEM_WIDTH-1:0]  rd_value_ext;
   logic [VALUE_W-1:0]             rd_value;
   logic [COUNT_OUT_W+CNT_W-1:0]   count_out_ext;
   logic [CNT_W:0]                 nxt1, nxt2;
   logic [CNT_W-1:0]               cnt_m1;
   logic                           more1, more2;
   logic                           hit;

   bsr_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEM_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Width adaptation between fixed payload fields and entry width
   assign req_value_ext = {{ELEM_WIDTH{1'b0}}, req_data.value_in};
   assign req_value     = req_value_ext[ELEM_WIDTH-1:0];
   assign rd_value_ext  = {{VALUE_W{1'b0}}, rd_data};
   assign rd_value      = rd_value_ext[VALUE_W-1:0];
   assign count_out_ext = {{COUNT_OUT_W{1'b0}}, count_in};

   // Walk pointers, one bit wider so the limit compare cannot wrap
   assign nxt1   = {1'b0, idx_ff} + (CNT_W+1)'(1);
   assign nxt2   = {1'b0, idx_ff} + (CNT_W+1)'(2);
   assign more1  = nxt1 < {1'b0, count_ff};
   assign more2  = nxt2 < {1'b0, count_ff};
   assign cnt_m1 = count_ff - CNT_W'(1);

   // The shared equality unit used by the search
   assign hit = (rd_data == val_ff);

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      val_in     = val_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff[IDX_W-1:0];
      wr_data    = rd_data;
      rd_en      = 1'b0;
      rd_addr    = nxt1[IDX_W-1:0];
      rsp_load   = 1'b0;
      rsp_status = ST_OK;
      rsp_value  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               val_in = req_value;
               idx_in = '0;
               unique case (req_data.req_type)
                  OP_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff == CAP_CNT) begin
                        rsp_status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IDX_W-1:0];
                        wr_data  = req_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP: begin
                     rsp_load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_status = ST_EMPTY;
                     end else begin
                        count_in = cnt_m1;
                     end
                  end
                  OP_PEEK: begin
                     if (count_ff == '0) begin
                        rsp_load   = 1'b1;
                        rsp_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_m1[IDX_W-1:0];
                        state_in = S_PEEK;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_load   = 1'b1;
                        rsp_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_load = 1'b1;
                     count_in = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_PEEK: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               rsp_value = rd_value;
               state_in  = S_IDLE;
            end
         end
         S_SEARCH: begin
            // Data for idx arrives now; fetch the next entry in the same cycle
            rd_en   = more1;
            rd_addr = nxt1[IDX_W-1:0];
            if (hit) begin
               state_in = S_SHIFT;
            end else if (more1) begin
               idx_in = nxt1[CNT_W-1:0];
            end else if (out_free) begin
               rsp_load   = 1'b1;
               rsp_status = ST_NOT_FOUND;
               state_in   = S_IDLE;
            end
         end
         S_SHIFT: begin
            // rd_data holds entry idx+1; move it down one place
            if (more1) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[IDX_W-1:0];
               wr_data = rd_data;
               rd_en   = more2;
               rd_addr = nxt2[IDX_W-1:0];
               idx_in  = nxt1[CNT_W-1:0];
            end else if (out_free) begin
               count_in = cnt_m1;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.status    = rsp_status;
         rsp_data_in.value_out = rsp_value;
         rsp_data_in.count_out = count_out_ext[COUNT_OUT_W-1:0];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.req_type == OP_PUSH && count_ff != CAP_CNT)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("accepted push did not add an entry");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_SHIFT) |-> idx_ff < count_ff)
      else $error("remove walk pointer beyond held entries");

endmodule

### bench/bounded_stack_with_remove_tb.sv
// Self-checking bench for bounded_stack_with_remove: directed table, then random traffic.
// Depends on bsr_pkg and the RTL top level; a local stack model predicts untyped responses.
`timescale 1ns / 100ps

module bounded_stack_with_remove_tb;
   import bsr_pkg::*;

   localparam int STACK_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 650;
   localparam int SEGMENT_LEN  = 40;
   localparam int TAIL_CYCLES  = 2 * STACK_DEPTH + 8;
   localparam int CYCLE_LIMIT  = 200000;

   // request codes the block treats as no-ops
   localparam logic [REQ_TYPE_W-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [REQ_TYPE_W-1:0] OP_UNUSED_HI = 3'd7;

   typedef struct {
      logic [REQ_TYPE_W-1:0]  op;
      logic [VALUE_W-1:0]     value;
      int                     reps;
      bit                     typed;
      logic [STATUS_W-1:0]    st;
      logic [VALUE_W-1:0]     vout;
      logic [COUNT_OUT_W-1:0] cnt;
   } plan_row_type;

   // Directed rows; typed = 0 means the response comes from the stack model
   plan_row_type directed_plan [0:13] = '{
      '{OP_PEEK,      32'h0000_0000,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
      '{OP_POP,       32'h0000_0000,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
      '{OP_REMOVE,    32'hFFFF_FFFF,  1, 1'b1, ST_EMPTY,     32'h0000_0000, 5'd0},
      '{OP_CLEAR,     32'h0000_0000,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0},
      '{OP_PUSH,      32'h0000_0000,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd1},
      '{OP_PUSH,      32'hFFFF_FFFF,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd2},
      '{OP_PEEK,      32'h0000_0000,  1, 1'b1, ST_OK,        32'hFFFF_FFFF, 5'd2},
      '{OP_REMOVE,    32'h0001_2345,  1, 1'b1, ST_NOT_FOUND, 32'h0000_0000, 5'd2},
      '{OP_REMOVE,    32'h0000_0000,  1, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
      '{OP_UNUSED_HI, 32'h5555_AAAA,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd1},
      '{OP_PUSH,      32'h8000_0000, 15, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
      '{OP_PUSH,      32'h7FFF_FFFF,  1, 1'b1, ST_FULL,      32'h0000_0000, 5'd16},
      '{OP_REMOVE,    32'h8000_0007,  1, 1'b0, ST_OK,        32'h0000_0000, 5'd0},
      '{OP_CLEAR,     32'h0000_0000,  1, 1'b1, ST_OK,        32'h0000_0000, 5'd0}
   };

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   bsr_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   bsr_rsp_type rsp_data;

   // stack model state
   logic [VALUE_W-1:0] held_entries [STACK_DEPTH];
   int                 held_count = 0;

   bsr_rsp_type pending_rsp [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          steady      = 1'b0;

   always #4 clock = ~clock;

   bounded_stack_with_remove #(
      .CAPACITY   (STACK_DEPTH),
      .ELEM_WIDTH (VALUE_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Stack model: apply one request, return the response it should give
   function automatic bsr_rsp_type stack_apply(input bsr_req_type r);
      bsr_rsp_type rsp;
      int          hit;
      rsp        = '0;
      rsp.status = ST_OK;
      case (r.req_type)
         OP_PUSH: begin
            if (held_count >= STACK_DEPTH) begin
               rsp.status = ST_FULL;
            end else begin
               held_entries[held_count] = r.value_in;
               held_count++;
            end
         end
         OP_POP: begin
            if (held_count == 0) rsp.status = ST_EMPTY;
            else held_count--;
         end
         OP_PEEK: begin
            if (held_count == 0) rsp.status = ST_EMPTY;
            else rsp.value_out = held_entries[held_count-1];
         end
         OP_REMOVE: begin
            if (held_count == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               // first match from the bottom, then close the gap
               hit = -1;
               for (int i = 0; i < held_count; i++)
                  if (hit < 0 && held_entries[i] == r.value_in) hit = i;
               if (hit < 0) begin
                  rsp.status = ST_NOT_FOUND;
               end else begin
                  for (int i = hit; i + 1 < held_count; i++)
                     held_entries[i] = held_entries[i+1];
                  held_count--;
               end
            end
         end
         OP_CLEAR: held_count = 0;
         default: ;
      endcase
      rsp.count_out = COUNT_OUT_W'(held_count);
      return rsp;
   endfunction

   // Offer one request after an idle gap; record the expected response on acceptance
   task automatic send_request(input bsr_req_type r, input int gap, input bit typed,
                               input bsr_rsp_type typed_rsp);
      bsr_rsp_type predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = stack_apply(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // Hold off the sender until every outstanding response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   // Response side: random stall per transaction, then compare with the oldest expectation
   initial begin : result_sink
      int          hold;
      bsr_rsp_type want;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected, actual status %0d value %h count %0d",
                     $time, rsp_data.status, rsp_data.value_out, rsp_data.count_out);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.value_out !== want.value_out) begin
               $display("%0t: value_out mismatch, expected %h, actual %h",
                        $time, want.value_out, rsp_data.value_out);
               error_count++;
            end
            if (rsp_data.count_out !== want.count_out) begin
               $display("%0t: count_out mismatch, expected %0d, actual %0d",
                        $time, want.count_out, rsp_data.count_out);
               error_count++;
            end
         end
      end
   end

   // Request side: directed table, then random traffic
   initial begin : stimulus
      bsr_req_type r;
      bsr_rsp_type typed_rsp;
      int          gap;
      int          roll;
      int          push_w;
      int          seg;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (directed_plan[n]) begin
         for (int k = 0; k < directed_plan[n].reps; k++) begin
            r.req_type          = directed_plan[n].op;
            r.value_in          = directed_plan[n].value + k;
            typed_rsp.status    = directed_plan[n].st;
            typed_rsp.value_out = directed_plan[n].vout;
            typed_rsp.count_out = directed_plan[n].cnt;
            send_request(r, $urandom_range(0, 13), directed_plan[n].typed, typed_rsp);
         end
      end
      drain_responses();

      // random traffic in segments: alternate filling and emptying, some with no idling
      typed_rsp = '0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         seg    = i / SEGMENT_LEN;
         steady = (seg % 3 == 2);
         push_w = (seg % 2 == 0) ? 55 : 25;
         if (i == RANDOM_ITEMS / 2) drain_responses();

         roll = $urandom_range(0, 99);
         if (roll < push_w)           r.req_type = OP_PUSH;
         else if (roll < push_w + 15) r.req_type = OP_POP;
         else if (roll < push_w + 27) r.req_type = OP_PEEK;
         else if (roll < 96)          r.req_type = OP_REMOVE;
         else if (roll < 98)          r.req_type = OP_CLEAR;
         else r.req_type = REQ_TYPE_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));

         // values: held entries for remove hits, a small pool for duplicates, or anything
         roll = $urandom_range(0, 9);
         if (roll < 4 && held_count > 0)
            r.value_in = held_entries[$urandom_range(0, held_count - 1)];
         else if (roll < 7)
            r.value_in = VALUE_W'($urandom_range(0, 5));
         else
            r.value_in = $urandom();

         gap = steady ? 0 : $urandom_range(0, 13);
         send_request(r, gap, 1'b0, typed_rsp);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/bsr_pkg.sv
rtl/bsr_store.sv
rtl/bounded_stack_with_remove.sv
bench/bounded_stack_with_remove_tb.sv
